/* hw/rtl/rrts_pkg.sv */
// Shared types, codes and helpers for the round-robin thread scheduler.
`default_nettype none
package rrts_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [2:0] MODE_CREATE  = 3'd0;
   localparam logic [2:0] MODE_YIELD   = 3'd1;
   localparam logic [2:0] MODE_EXIT    = 3'd2;
   localparam logic [2:0] MODE_SLEEP   = 3'd3;
   localparam logic [2:0] MODE_BLOCK   = 3'd4;
   localparam logic [2:0] MODE_UNBLOCK = 3'd5;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   localparam logic [2:0] SLOT_UNUSED   = 3'd0;
   localparam logic [2:0] SLOT_READY    = 3'd1;
   localparam logic [2:0] SLOT_RUNNING  = 3'd2;
   localparam logic [2:0] SLOT_SLEEPING = 3'd3;
   localparam logic [2:0] SLOT_BLOCKED  = 3'd4;
   localparam logic [2:0] SLOT_DEAD     = 3'd5;

   // ms to seconds, rounded up: (ms + 999) / 1000 = ((ms + 999) >> 3) / 125
   localparam int MS_ROUND   = 999;
   localparam int DIV_N_W    = 33;
   localparam int DIV_Q_W    = 30;
   localparam int PROD_W     = 61;
   localparam int RECIP_SHIFT = 37;
   // ceil(2^37 / 125); exact for every 30-bit value
   localparam logic [30:0] SEC_RECIP = 31'd1099511628;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] now_seconds;
      logic [31:0] sleep_ms;
      logic [15:0] target_tid;
   } req_type;

   typedef struct packed {
      logic [15:0] running_tid;
      logic [15:0] new_tid;
      logic [1:0]  status;
      logic        switched;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  state;
      logic [15:0] tid;
      logic [31:0] wake;
   } slot_type;

   function automatic slot_type wake_slot(input slot_type s, input logic [31:0] now);
      slot_type r;
      r = s;
      if (s.state == SLOT_SLEEPING && now >= s.wake) begin
         r.state = SLOT_READY;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/round_robin_thread_scheduler.sv */
// Top level: thread table ring, request sequencer and result register.
`default_nettype none
// The thread table is a ring of SLOTS cells that rotates one slot per cycle, during the
// three passes of a request only, past a single head position where all checks and
// updates happen. Every request takes three full rotations: wake sleepers and locate
// slots, apply the operation and choose the next ready slot, then commit the switch. A
// sleep request first passes through the reciprocal-multiply ms-to-seconds conversion.
// One request is in work at a time; the next one is taken as soon as the result is in
// the output register.
module round_robin_thread_scheduler (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  rrts_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output rrts_pkg::rsp_type   rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_A    = 3'd2;
   localparam logic [2:0] S_B    = 3'd3;
   localparam logic [2:0] S_C    = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam int IW = rrts_pkg::IDX_W;
   localparam logic [IW-1:0] LAST = IW'(rrts_pkg::SLOTS-1);

   logic [2:0]          state_ff, state_in;
   logic [IW-1:0]       pos_ff, pos_in;
   rrts_pkg::req_type   req_ff;
   logic [15:0]         running_id_ff, next_id_ff;
   logic                free_v_ff, cur_v_ff, hit_v_ff, hit_blk_ff, run_v_ff, pa_v_ff, pb_v_ff;
   logic [IW-1:0]       free_ff, cur_ff, hit_ff, run_ff, pa_ff, pb_ff;
   logic [15:0]         pa_tid_ff, pb_tid_ff;
   logic [31:0]         secs_ff;
   logic                rsp_valid_ff;
   rrts_pkg::rsp_type   rsp_ff;

   rrts_pkg::slot_type  slot_w [rrts_pkg::SLOTS];
   rrts_pkg::slot_type  head, head_nxt;
   logic                shift;
   logic                accept, at_end;
   logic                div_done;
   logic [31:0]         div_q;
   logic [IW-1:0]       start_idx, pick_idx;
   logic                pick_v, resched, do_sw, create_ok;
   logic [15:0]         pick_tid;
   logic [31:0]         wake_new;

   genvar gi;
   generate
      for (gi = 0; gi < rrts_pkg::SLOTS; gi++) begin : g_cell
         rrts_pkg::slot_type init_w;
         rrts_pkg::slot_type nxt_w;
         assign init_w = '{state: (gi == 0) ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_UNUSED,
                           tid: 16'd0, wake: 32'd0};
         if (gi == rrts_pkg::SLOTS-1) begin : g_tail
            assign nxt_w = head_nxt;
         end else begin : g_mid
            assign nxt_w = slot_w[gi+1];
         end
         rrts_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .init_slot (init_w),
            .slot_nxt  (nxt_w),
            .slot_out  (slot_w[gi])
         );
      end
   endgenerate

   rrts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && req_data.mode == rrts_pkg::MODE_SLEEP),
      .dividend ({1'b0, req_data.sleep_ms} + 33'(rrts_pkg::MS_ROUND)),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign shift     = (state_ff inside {S_A, S_B, S_C});
   assign at_end    = (pos_ff == LAST);
   assign head      = slot_w[0];

   always_comb begin
      start_idx = '0;
      if (cur_v_ff && cur_ff != LAST) begin
         start_idx = cur_ff + 1'b1;
      end
      pick_v    = pa_v_ff || pb_v_ff;
      pick_idx  = pa_v_ff ? pa_ff : pb_ff;
      pick_tid  = pa_v_ff ? pa_tid_ff : pb_tid_ff;
      resched   = (req_ff.mode inside {rrts_pkg::MODE_YIELD, rrts_pkg::MODE_EXIT}) ||
                  ((req_ff.mode inside {rrts_pkg::MODE_SLEEP, rrts_pkg::MODE_BLOCK}) &&
                   cur_v_ff);
      do_sw     = resched && pick_v && !(run_v_ff && pick_idx == run_ff);
      create_ok = (req_ff.mode == rrts_pkg::MODE_CREATE) && free_v_ff;
      wake_new  = req_ff.now_seconds + secs_ff;
   end

   // head rewrite, by pass
   always_comb begin
      head_nxt = head;
      case (state_ff)
         S_A: begin
            head_nxt = rrts_pkg::wake_slot(head, req_ff.now_seconds);
         end
         S_B: begin
            case (req_ff.mode)
               rrts_pkg::MODE_CREATE: begin
                  if (free_v_ff && pos_ff == free_ff) begin
                     head_nxt.state = rrts_pkg::SLOT_READY;
                     head_nxt.tid   = next_id_ff;
                     head_nxt.wake  = '0;
                  end
               end
               rrts_pkg::MODE_EXIT: begin
                  if (cur_v_ff && pos_ff == cur_ff) head_nxt.state = rrts_pkg::SLOT_DEAD;
               end
               rrts_pkg::MODE_SLEEP: begin
                  if (cur_v_ff && pos_ff == cur_ff) begin
                     head_nxt.state = rrts_pkg::SLOT_SLEEPING;
                     head_nxt.wake  = wake_new;
                  end
               end
               rrts_pkg::MODE_BLOCK: begin
                  if (cur_v_ff && pos_ff == cur_ff) head_nxt.state = rrts_pkg::SLOT_BLOCKED;
               end
               rrts_pkg::MODE_UNBLOCK: begin
                  if (hit_v_ff && hit_blk_ff && pos_ff == hit_ff) begin
                     head_nxt.state = rrts_pkg::SLOT_READY;
                  end
               end
               default: begin
                  head_nxt = head;
               end
            endcase
            // second wake catches a wrapped sleep time
            head_nxt = rrts_pkg::wake_slot(head_nxt, req_ff.now_seconds);
         end
         S_C: begin
            if (do_sw && run_v_ff && pos_ff == run_ff) head_nxt.state = rrts_pkg::SLOT_READY;
            if (do_sw && pos_ff == pick_idx) head_nxt.state = rrts_pkg::SLOT_RUNNING;
         end
         default: begin
            head_nxt = head;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = (req_data.mode == rrts_pkg::MODE_SLEEP) ? S_DIV : S_A;
            pos_in = '0;
         end
         S_DIV: begin
            if (div_done) state_in = S_A;
         end
         S_A, S_B, S_C: begin
            pos_in = at_end ? '0 : pos_ff + 1'b1;
            if (at_end) state_in = (state_ff == S_A) ? S_B : (state_ff == S_B) ? S_C : S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         running_id_ff <= 16'd0;
         next_id_ff    <= 16'd1;
         rsp_valid_ff  <= 1'b0;
         free_v_ff     <= 1'b0;
         cur_v_ff      <= 1'b0;
         hit_v_ff      <= 1'b0;
         run_v_ff      <= 1'b0;
         pa_v_ff       <= 1'b0;
         pb_v_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         if (accept) begin
            free_v_ff <= 1'b0;
            cur_v_ff  <= 1'b0;
            hit_v_ff  <= 1'b0;
            run_v_ff  <= 1'b0;
            pa_v_ff   <= 1'b0;
            pb_v_ff   <= 1'b0;
         end
         if (state_ff == S_A) begin
            if (!free_v_ff && head_nxt.state == rrts_pkg::SLOT_UNUSED) begin
               free_v_ff <= 1'b1;
               free_ff   <= pos_ff;
            end
            if (!cur_v_ff && head_nxt.state != rrts_pkg::SLOT_UNUSED &&
                head_nxt.tid == running_id_ff) begin
               cur_v_ff <= 1'b1;
               cur_ff   <= pos_ff;
            end
            if (!hit_v_ff && head_nxt.state != rrts_pkg::SLOT_UNUSED &&
                head_nxt.tid == req_ff.target_tid) begin
               hit_v_ff   <= 1'b1;
               hit_ff     <= pos_ff;
               hit_blk_ff <= (head_nxt.state == rrts_pkg::SLOT_BLOCKED);
            end
         end
         if (state_ff == S_B) begin
            if (!run_v_ff && head_nxt.state == rrts_pkg::SLOT_RUNNING &&
                head_nxt.tid == running_id_ff) begin
               run_v_ff <= 1'b1;
               run_ff   <= pos_ff;
            end
            if (head_nxt.state == rrts_pkg::SLOT_READY) begin
               if (!pa_v_ff && pos_ff >= start_idx) begin
                  pa_v_ff   <= 1'b1;
                  pa_ff     <= pos_ff;
                  pa_tid_ff <= head_nxt.tid;
               end
               if (!pb_v_ff) begin
                  pb_v_ff   <= 1'b1;
                  pb_ff     <= pos_ff;
                  pb_tid_ff <= head_nxt.tid;
               end
            end
         end
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
            if (do_sw) running_id_ff <= pick_tid;
            if (create_ok) next_id_ff <= next_id_ff + 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         req_ff  <= req_data;
         secs_ff <= 32'd1;
      end
      if (div_done) begin
         secs_ff <= (div_q == 32'd0) ? 32'd1 : div_q;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.running_tid <= do_sw ? pick_tid : running_id_ff;
         rsp_ff.new_tid     <= create_ok ? next_id_ff : 16'd0;
         rsp_ff.switched    <= do_sw;
         if (req_ff.mode == rrts_pkg::MODE_CREATE && !free_v_ff) begin
            rsp_ff.status <= rrts_pkg::STATUS_FULL;
         end else if (((req_ff.mode inside {rrts_pkg::MODE_SLEEP, rrts_pkg::MODE_BLOCK}) &&
                       !cur_v_ff) ||
                      (req_ff.mode == rrts_pkg::MODE_UNBLOCK && !(hit_v_ff && hit_blk_ff)) ||
                      (req_ff.mode > rrts_pkg::MODE_UNBLOCK)) begin
            rsp_ff.status <= rrts_pkg::STATUS_IGNORED;
         end else begin
            rsp_ff.status <= rrts_pkg::STATUS_DONE;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> pos_ff == '0)
      else $error("ring position not home while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the final step");

   a_new_tid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.new_tid != 16'd0 |-> rsp_ff.status == rrts_pkg::STATUS_DONE)
      else $error("new id reported on a failed request");

   a_sw_only_resched: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && do_sw |-> resched && pick_v)
      else $error("switch without a reschedule");

endmodule
`default_nettype wire

/* hw/rtl/rrts_cell.sv */
// One slot of the thread table; a ring stage that takes its neighbor's slot on shift.
`default_nettype none
module rrts_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     shift,
   input  rrts_pkg::slot_type      init_slot,
   input  rrts_pkg::slot_type      slot_nxt,
   output rrts_pkg::slot_type      slot_out
);

   rrts_pkg::slot_type slot_ff;
   rrts_pkg::slot_type slot_in;

   always_comb begin
      slot_in = shift ? slot_nxt : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= init_slot;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

endmodule
`default_nettype wire

/* hw/rtl/rrts_div.sv */
// Ms-to-seconds quotient by reciprocal multiplication; operand, then product, are registered before done.
`default_nettype none
module rrts_div (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire [rrts_pkg::DIV_N_W-1:0]     dividend,
   output logic                            done,
   output logic [31:0]                     quotient
);

   logic [rrts_pkg::DIV_Q_W-1:0] num_ff;
   logic [rrts_pkg::PROD_W-1:0]  prod_ff;
   logic                         stage_ff;
   logic                         done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
      if (start) begin
         num_ff <= dividend[rrts_pkg::DIV_N_W-1:3];
      end
      if (stage_ff) begin
         prod_ff <= rrts_pkg::PROD_W'(num_ff) * rrts_pkg::PROD_W'(rrts_pkg::SEC_RECIP);
      end
   end

   assign done     = done_ff;
   assign quotient = {8'd0, prod_ff[rrts_pkg::PROD_W-1:rrts_pkg::RECIP_SHIFT]};

endmodule
`default_nettype wire
